// File: hw/rtl/run_length_table_decoder_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the run-length table decoder
// Concurrent checks sampled on i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef RUN_LENGTH_TABLE_DECODER_UNIT_MACROS_SVH
`define RUN_LENGTH_TABLE_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define RLTD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("run length decoder check failed");

// Next-cycle implication.
`define RLTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("run length decoder check failed");

`else

`define RLTD_ASSERT_NOW(label, ante, cons)
`define RLTD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hw/rtl/rltd_pkg.sv
// ---------------------------------------------------------------------------
// Run-length table decoder package
// Shared codes, sizes and request types of the decoder.
// ---------------------------------------------------------------------------
package rltd_pkg;

    localparam int unsigned POS_W   = 12;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned PHASE_W = 3;

    // Size of the decoded table in bytes.
    localparam logic [POS_W-1:0] TABLE_BYTES = 12'd2560;

    // Input request kinds.
    localparam logic OP_SIZE = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    // Decoder phases.
    localparam logic [PHASE_W-1:0] PH_SIZE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HEADER  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_FILL    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LITERAL = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_FAILED  = 3'd5;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_ACCEPT  = 3'd0;
    localparam logic [STAT_W-1:0] ST_WRITE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADSIZE = 3'd2;
    localparam logic [STAT_W-1:0] ST_OVERRUN = 3'd3;
    localparam logic [STAT_W-1:0] ST_IGNORED = 3'd4;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] payload;
    } t_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  start;
        logic [CNT_W-1:0]  count;
        logic [BYTE_W-1:0] data;
        logic              finished;
    } t_result;

endpackage

// File: hw/rtl/rltd_in_stage.sv
// ---------------------------------------------------------------------------
// Run-length table decoder input register
// Holds one incoming request until the decode logic takes it.
// ---------------------------------------------------------------------------
module rltd_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rltd_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output rltd_pkg::t_item o_item
);

    logic            r_valid;
    rltd_pkg::t_item r_item;

    // Room when empty or when the held request leaves this cycle.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// File: hw/rtl/rltd_core.sv
// ---------------------------------------------------------------------------
// Run-length table decoder core
// Phase and position state with the single-pass decode of one request.
// ---------------------------------------------------------------------------
module rltd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  rltd_pkg::t_item   i_item,
    output rltd_pkg::t_result o_result
);

    logic [rltd_pkg::PHASE_W-1:0] r_phase,    n_phase;
    logic [rltd_pkg::POS_W-1:0]   r_position, n_position;
    logic [rltd_pkg::CNT_W-1:0]   r_literal,  n_literal;
    logic [rltd_pkg::CNT_W-1:0]   r_fill,     n_fill;

    logic [rltd_pkg::BYTE_W-1:0]  w_byte;
    logic [rltd_pkg::CNT_W-1:0]   w_count;
    logic [rltd_pkg::POS_W:0]     w_hdr_sum;
    logic [rltd_pkg::POS_W-1:0]   w_fill_pos;
    logic [rltd_pkg::POS_W-1:0]   w_lit_pos;
    logic [rltd_pkg::CNT_W-1:0]   w_lit_left;

    assign w_byte     = i_item.payload[rltd_pkg::BYTE_W-1:0];
    assign w_count    = w_byte[rltd_pkg::CNT_W-1:0];
    assign w_hdr_sum  = {1'b0, r_position} + (rltd_pkg::POS_W+1)'(w_count);
    assign w_fill_pos = r_position + rltd_pkg::POS_W'(r_fill);
    assign w_lit_pos  = r_position + rltd_pkg::POS_W'(1);
    assign w_lit_left = r_literal - rltd_pkg::CNT_W'(1);

    always_comb begin
        n_phase    = r_phase;
        n_position = r_position;
        n_literal  = r_literal;
        n_fill     = r_fill;
        o_result   = '0;

        unique case (r_phase) inside
            rltd_pkg::PH_DONE, rltd_pkg::PH_FAILED: begin
                o_result.status = rltd_pkg::ST_IGNORED;
            end
            rltd_pkg::PH_SIZE: begin
                if (i_item.op != rltd_pkg::OP_SIZE) begin
                    o_result.status = rltd_pkg::ST_IGNORED;
                end else if (i_item.payload !=
                             rltd_pkg::WORD_W'(rltd_pkg::TABLE_BYTES)) begin
                    o_result.status = rltd_pkg::ST_BADSIZE;
                    n_phase         = rltd_pkg::PH_FAILED;
                end else begin
                    o_result.status = rltd_pkg::ST_ACCEPT;
                    n_phase         = rltd_pkg::PH_HEADER;
                end
            end
            rltd_pkg::PH_HEADER: begin
                if (i_item.op != rltd_pkg::OP_BYTE) begin
                    o_result.status = rltd_pkg::ST_IGNORED;
                end else if (w_hdr_sum >
                             (rltd_pkg::POS_W+1)'(rltd_pkg::TABLE_BYTES)) begin
                    // The run check is made on the header itself.
                    o_result.status = rltd_pkg::ST_OVERRUN;
                    n_phase         = rltd_pkg::PH_FAILED;
                end else if (w_byte[rltd_pkg::BYTE_W-1]) begin
                    o_result.status = rltd_pkg::ST_ACCEPT;
                    n_fill          = w_count;
                    n_phase         = rltd_pkg::PH_FILL;
                end else if (w_count == '0) begin
                    o_result.status   = rltd_pkg::ST_ACCEPT;
                    o_result.finished = 1'b1;
                    n_phase           = rltd_pkg::PH_DONE;
                end else begin
                    o_result.status = rltd_pkg::ST_ACCEPT;
                    n_literal       = w_count;
                    n_phase         = rltd_pkg::PH_LITERAL;
                end
            end
            rltd_pkg::PH_FILL: begin
                if (i_item.op != rltd_pkg::OP_BYTE) begin
                    o_result.status = rltd_pkg::ST_IGNORED;
                end else begin
                    n_fill = '0;
                    if (r_fill == '0) begin
                        // A fill of zero length still eats its byte and ends.
                        o_result.status   = rltd_pkg::ST_ACCEPT;
                        o_result.finished = 1'b1;
                        n_phase           = rltd_pkg::PH_DONE;
                    end else begin
                        o_result.status = rltd_pkg::ST_WRITE;
                        o_result.start  = r_position;
                        o_result.count  = r_fill;
                        o_result.data   = w_byte;
                        n_position      = w_fill_pos;
                        if (w_fill_pos >= rltd_pkg::TABLE_BYTES) begin
                            o_result.finished = 1'b1;
                            n_phase           = rltd_pkg::PH_DONE;
                        end else begin
                            n_phase = rltd_pkg::PH_HEADER;
                        end
                    end
                end
            end
            rltd_pkg::PH_LITERAL: begin
                if (i_item.op != rltd_pkg::OP_BYTE) begin
                    o_result.status = rltd_pkg::ST_IGNORED;
                end else begin
                    o_result.status = rltd_pkg::ST_WRITE;
                    o_result.start  = r_position;
                    o_result.count  = rltd_pkg::CNT_W'(1);
                    o_result.data   = w_byte;
                    n_position      = w_lit_pos;
                    n_literal       = w_lit_left;
                    if (w_lit_left == '0) begin
                        if (w_lit_pos >= rltd_pkg::TABLE_BYTES) begin
                            o_result.finished = 1'b1;
                            n_phase           = rltd_pkg::PH_DONE;
                        end else begin
                            n_phase = rltd_pkg::PH_HEADER;
                        end
                    end
                end
            end
            default: begin
                // Codes with no meaning fall into the failed phase.
                o_result.status = rltd_pkg::ST_IGNORED;
                n_phase         = rltd_pkg::PH_FAILED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= rltd_pkg::PH_SIZE;
            r_position <= '0;
            r_literal  <= '0;
            r_fill     <= '0;
        end else if (i_take) begin
            r_phase    <= n_phase;
            r_position <= n_position;
            r_literal  <= n_literal;
            r_fill     <= n_fill;
        end
    end

endmodule

// File: hw/rtl/rltd_out_stage.sv
// ---------------------------------------------------------------------------
// Run-length table decoder result register
// Holds one decoded result until the downstream side takes it.
// ---------------------------------------------------------------------------
module rltd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  rltd_pkg::t_result i_result,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_ready,
    output rltd_pkg::t_result o_result
);

    logic              r_valid;
    rltd_pkg::t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: hw/rtl/run_length_table_decoder_unit.sv
// ---------------------------------------------------------------------------
// Run-length table decoder unit
// Turns a run-length coded byte stream into table write descriptors.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  tdata (low bit up)               tuser       tlast
//  s_axis    in         payload[31:0]                    operation   -
//  m_axis    out        start[11:0] count[18:12]         status      finished
//                       byte[26:19], zero[31:27]
//
// Every request gives exactly one result, held first in the input register and then in the result register.
// A request is accepted in every cycle while results drain; throughput is one
// per cycle, set by the phase update made as a request moves from the input
// register to the result register.
// Reset is synchronous and active low; it returns the decoder to waiting for
// the size word and empties both registers. A stall on m_axis holds the
// result register and backs up into s_axis tready once the input register is full.
// ---------------------------------------------------------------------------
`include "run_length_table_decoder_unit_macros.svh"

module run_length_table_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // payload[31:0]
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // start[11:0], count[18:12], byte[26:19]
    output logic [2:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast    // finished
);

    rltd_pkg::t_item   w_in_item;
    rltd_pkg::t_item   w_held_item;
    rltd_pkg::t_result w_core_result;
    rltd_pkg::t_result w_out_result;
    logic              w_held_valid;
    logic              w_can_load;
    logic              w_take;

    assign w_in_item.op      = s_axis_tuser;
    assign w_in_item.payload = s_axis_tdata;

    // The held request is decoded and stored in the same cycle.
    assign w_take = w_held_valid && w_can_load;

    rltd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .i_take  (w_take),
        .o_valid (w_held_valid),
        .o_item  (w_held_item)
    );

    rltd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_take),
        .i_item   (w_held_item),
        .o_result (w_core_result)
    );

    rltd_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_take),
        .i_result   (w_core_result),
        .o_can_load (w_can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (w_out_result)
    );

    assign m_axis_tdata = {5'b0, w_out_result.data, w_out_result.count,
                           w_out_result.start};
    assign m_axis_tuser = w_out_result.status;
    assign m_axis_tlast = w_out_result.finished;

    // A write always covers at least one position and stays inside the table.
    `RLTD_ASSERT_NOW(a_write_nonempty, m_axis_tvalid && m_axis_tuser == rltd_pkg::ST_WRITE, m_axis_tdata[18:12] != 7'd0)
    `RLTD_ASSERT_NOW(a_write_in_table, m_axis_tvalid && m_axis_tuser == rltd_pkg::ST_WRITE, ({1'b0, m_axis_tdata[11:0]} + {6'b0, m_axis_tdata[18:12]}) <= {1'b0, rltd_pkg::TABLE_BYTES})
    // Only an accept or a write can end decoding.
    `RLTD_ASSERT_NOW(a_finish_status, m_axis_tvalid && m_axis_tlast, m_axis_tuser == rltd_pkg::ST_ACCEPT || m_axis_tuser == rltd_pkg::ST_WRITE)
    // Results without a write carry an all-zero descriptor.
    `RLTD_ASSERT_NOW(a_idle_fields, m_axis_tvalid && m_axis_tuser != rltd_pkg::ST_WRITE, m_axis_tdata == 32'd0)

endmodule
